// File: sv/kdef_pkg.sv
// Shared types, constants and helpers for the key debounce event queue.
package kdef_pkg;

    localparam int unsigned CODE_W     = 4;
    localparam int unsigned KEYS_W     = 4;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned FT_W       = 7;
    localparam int unsigned LT_W       = 10;
    localparam int unsigned FC_W       = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned OPQ_DEPTH  = 4;
    localparam int unsigned OPQ_PTR_W  = 2;
    localparam int unsigned OPQ_CNT_W  = 3;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPEED = 2'd2;

    localparam logic [FT_W-1:0] FILTER_TIME_RST  = 7'd5;
    localparam logic [LT_W-1:0] LONG_TIME_RST    = 10'd100;
    localparam logic [LT_W-1:0] REPEAT_SPEED_RST = 10'd0;
    localparam logic [FC_W-1:0] FILTER_COUNT_RST = 8'd2;

    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEYS_W-1:0] keys_down;
    } t_in_req;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              queue_empty;
    } t_out_rsp;

    typedef struct packed {
        logic [FT_W-1:0] filter_time;
        logic [LT_W-1:0] long_time;
        logic [LT_W-1:0] repeat_speed;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
    } t_op_req;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_KEY,
        SCAN_SECOND
    } t_scan_state;

    function automatic logic [CODE_W-1:0] key_code(logic [2:0] key, logic [1:0] ev);
        logic [5:0] full_code;
        full_code = 6'(key) * 6'd3 + 6'(ev);
        return full_code[CODE_W-1:0];
    endfunction

endpackage

// File: sv/kdef_scan.sv
// Front end: accepts requests and runs the per-key debounce sequencer on scan ticks.
module kdef_scan #(
    parameter int NUM_KEYS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kdef_pkg::t_cfg        i_cfg,
    input  logic                  i_req_valid,
    input  kdef_pkg::t_in_req     i_req,
    output logic                  o_req_ready,
    input  logic                  i_opq_full,
    output logic                  o_op_valid,
    output kdef_pkg::t_op_req     o_op
);

    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(NUM_KEYS - 1);

    kdef_pkg::t_scan_state r_state, n_state;
    logic [KEY_IDX_W-1:0]          r_key;
    logic [NUM_KEYS-1:0]           r_keys;
    logic [kdef_pkg::CODE_W-1:0]   r_code_b;
    logic [kdef_pkg::FC_W-1:0]     r_fc      [NUM_KEYS];
    logic                          r_pressed [NUM_KEYS];
    logic [kdef_pkg::LT_W-1:0]     r_hold    [NUM_KEYS];
    logic [kdef_pkg::LT_W-1:0]     r_rep     [NUM_KEYS];
    logic                          r_long    [NUM_KEYS];

    logic [NUM_KEYS+3:0]           w_keys_ext;
    logic [kdef_pkg::FC_W-1:0]     n_fc;
    logic                          n_pressed;
    logic [kdef_pkg::LT_W-1:0]     n_hold;
    logic [kdef_pkg::LT_W-1:0]     n_rep;
    logic                          n_long;
    logic                          w_down;
    logic [kdef_pkg::FC_W-1:0]     w_ft;
    logic [kdef_pkg::FC_W-1:0]     w_ft2;
    logic [kdef_pkg::CODE_W-1:0]   w_code_a;
    logic [kdef_pkg::CODE_W-1:0]   w_code_b;
    logic                          w_a_valid;
    logic                          w_b_valid;
    logic [kdef_pkg::CODE_W-1:0]   w_first_code;
    logic                          w_any_code;
    logic                          w_two_codes;
    logic                          w_accept;
    logic                          w_commit;
    logic                          w_save_b;
    logic                          w_advance;

    assign w_keys_ext   = (NUM_KEYS + 4)'(i_req.keys_down);
    assign w_down       = r_keys[r_key];
    assign w_ft         = {1'b0, i_cfg.filter_time};
    assign w_ft2        = {i_cfg.filter_time, 1'b0};
    assign w_first_code = w_a_valid ? w_code_a : w_code_b;
    assign w_any_code   = w_a_valid || w_b_valid;
    assign w_two_codes  = w_a_valid && w_b_valid;

    // Debounce, long-press and repeat update for the key under the sequencer.
    always_comb begin
        n_fc      = r_fc[r_key];
        n_pressed = r_pressed[r_key];
        n_hold    = r_hold[r_key];
        n_rep     = r_rep[r_key];
        n_long    = r_long[r_key];
        w_a_valid = 1'b0;
        w_b_valid = 1'b0;
        w_code_a  = kdef_pkg::key_code(3'(r_key), kdef_pkg::EV_PRESS);
        w_code_b  = kdef_pkg::key_code(3'(r_key), kdef_pkg::EV_LONG);
        if (w_down) begin
            if (r_fc[r_key] < w_ft) begin
                n_fc = w_ft;
            end else if (r_fc[r_key] < w_ft2) begin
                n_fc = r_fc[r_key] + 8'd1;
            end else begin
                if (!r_pressed[r_key]) begin
                    n_pressed = 1'b1;
                    w_a_valid = 1'b1;
                end
                if (i_cfg.long_time != '0) begin
                    if (r_hold[r_key] < i_cfg.long_time) begin
                        n_hold = r_hold[r_key] + 10'd1;
                        if (n_hold >= i_cfg.long_time) begin
                            n_long    = 1'b1;
                            w_b_valid = 1'b1;
                        end
                    end else if (i_cfg.repeat_speed != '0) begin
                        n_rep = r_rep[r_key] + 10'd1;
                        if (n_rep >= i_cfg.repeat_speed) begin
                            n_rep     = '0;
                            w_b_valid = 1'b1;
                            w_code_b  = kdef_pkg::key_code(3'(r_key), kdef_pkg::EV_PRESS);
                        end
                    end
                end
            end
        end else begin
            if (r_fc[r_key] > w_ft) begin
                n_fc = w_ft;
            end else if (r_fc[r_key] != '0) begin
                n_fc = r_fc[r_key] - 8'd1;
            end else if (r_pressed[r_key]) begin
                n_pressed = 1'b0;
                if (r_long[r_key]) begin
                    n_long = 1'b0;
                end else begin
                    w_a_valid = 1'b1;
                    w_code_a  = kdef_pkg::key_code(3'(r_key), kdef_pkg::EV_RELEASE);
                end
            end
            n_hold = '0;
            n_rep  = '0;
        end
    end

    always_comb begin
        w_accept    = 1'b0;
        w_commit    = 1'b0;
        w_save_b    = 1'b0;
        w_advance   = 1'b0;
        o_op_valid  = 1'b0;
        o_op.op     = kdef_pkg::OP_PUSH;
        o_op.code   = '0;
        o_req_ready = (r_state == kdef_pkg::SCAN_IDLE) && !i_opq_full;
        case (r_state)
            kdef_pkg::SCAN_IDLE: begin
                w_accept = i_req_valid && o_req_ready;
                if (w_accept) begin
                    case (i_req.kind)
                        kdef_pkg::KIND_POP: begin
                            o_op_valid = 1'b1;
                            o_op.op    = kdef_pkg::OP_POP;
                        end
                        kdef_pkg::KIND_CLEAR: begin
                            o_op_valid = 1'b1;
                            o_op.op    = kdef_pkg::OP_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            kdef_pkg::SCAN_KEY: begin
                if (!w_any_code) begin
                    w_commit  = 1'b1;
                    w_advance = 1'b1;
                end else if (!i_opq_full) begin
                    w_commit   = 1'b1;
                    o_op_valid = 1'b1;
                    o_op.code  = w_first_code;
                    if (w_two_codes) begin
                        w_save_b = 1'b1;
                    end else begin
                        w_advance = 1'b1;
                    end
                end
            end
            kdef_pkg::SCAN_SECOND: begin
                if (!i_opq_full) begin
                    o_op_valid = 1'b1;
                    o_op.code  = r_code_b;
                    w_advance  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kdef_pkg::SCAN_IDLE: begin
                if (w_accept && (i_req.kind == kdef_pkg::KIND_TICK)) begin
                    n_state = kdef_pkg::SCAN_KEY;
                end
            end
            kdef_pkg::SCAN_KEY: begin
                if (w_save_b) begin
                    n_state = kdef_pkg::SCAN_SECOND;
                end else if (w_advance && (r_key == LAST_KEY)) begin
                    n_state = kdef_pkg::SCAN_IDLE;
                end
            end
            kdef_pkg::SCAN_SECOND: begin
                if (w_advance) begin
                    n_state = (r_key == LAST_KEY) ? kdef_pkg::SCAN_IDLE : kdef_pkg::SCAN_KEY;
                end
            end
            default: n_state = kdef_pkg::SCAN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kdef_pkg::SCAN_IDLE;
            r_key   <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_fc[k]      <= kdef_pkg::FILTER_COUNT_RST;
                r_pressed[k] <= 1'b0;
                r_hold[k]    <= '0;
                r_rep[k]     <= '0;
                r_long[k]    <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_key <= '0;
            end else if (w_advance && (r_key != LAST_KEY)) begin
                r_key <= r_key + KEY_IDX_W'(1);
            end
            if (w_commit) begin
                r_fc[r_key]      <= n_fc;
                r_pressed[r_key] <= n_pressed;
                r_hold[r_key]    <= n_hold;
                r_rep[r_key]     <= n_rep;
                r_long[r_key]    <= n_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_keys <= w_keys_ext[NUM_KEYS-1:0];
        end
        if (w_save_b) begin
            r_code_b <= w_code_b;
        end
    end

endmodule

// File: sv/kdef_opq.sv
// Short operation queue between the scan front end and the event queue back end.
module kdef_opq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kdef_pkg::t_op_req i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output kdef_pkg::t_op_req o_data
);

    kdef_pkg::t_op_req                r_slot [kdef_pkg::OPQ_DEPTH];
    logic [kdef_pkg::OPQ_PTR_W-1:0]   r_wr;
    logic [kdef_pkg::OPQ_PTR_W-1:0]   r_rd;
    logic [kdef_pkg::OPQ_CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == kdef_pkg::OPQ_CNT_W'(kdef_pkg::OPQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + kdef_pkg::OPQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + kdef_pkg::OPQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + kdef_pkg::OPQ_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - kdef_pkg::OPQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/kdef_evq.sv
// Back end: event ring memory with push, pop and clear, plus a two-entry result buffer.
module kdef_evq #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  kdef_pkg::t_op_req  i_op,
    output logic               o_op_ready,
    input  logic               i_rsp_pop,
    output logic               o_rsp_empty,
    output kdef_pkg::t_out_rsp o_rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    logic [kdef_pkg::CODE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]            r_wr;
    logic [PTR_W-1:0]            r_rd;
    logic                        r_rd_valid;
    logic                        r_rd_none;
    logic [kdef_pkg::CODE_W-1:0] r_mem_q;
    kdef_pkg::t_out_rsp          r_oq [2];
    logic                        r_oq_wr;
    logic                        r_oq_rd;
    logic [1:0]                  r_oq_cnt;

    logic                        w_out_pop;
    logic                        w_credit;
    logic                        w_do;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_clear;
    logic                        w_empty;
    kdef_pkg::t_out_rsp          w_rsp_new;

    assign w_out_pop   = i_rsp_pop && (r_oq_cnt != '0);
    assign w_credit    = ({1'b0, r_oq_cnt} + {2'b00, r_rd_valid}) < (3'd2 + {2'b00, w_out_pop});
    assign o_op_ready  = (i_op.op != kdef_pkg::OP_POP) || w_credit;
    assign w_do        = i_op_valid && o_op_ready;
    assign w_push      = w_do && (i_op.op == kdef_pkg::OP_PUSH);
    assign w_pop       = w_do && (i_op.op == kdef_pkg::OP_POP);
    assign w_clear     = w_do && (i_op.op == kdef_pkg::OP_CLEAR);
    assign w_empty     = (r_rd == r_wr);

    assign w_rsp_new.event_code  = r_rd_none ? '0 : r_mem_q;
    assign w_rsp_new.queue_empty = r_rd_none;
    assign o_rsp_empty = (r_oq_cnt == '0);
    assign o_rsp       = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_op.code;
        end
        if (w_pop) begin
            r_mem_q <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd_none <= w_empty;
        end
        if (r_rd_valid) begin
            r_oq[r_oq_wr] <= w_rsp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_rd_valid <= 1'b0;
            r_oq_wr    <= 1'b0;
            r_oq_rd    <= 1'b0;
            r_oq_cnt   <= '0;
        end else begin
            r_rd_valid <= w_pop;
            if (w_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_clear) begin
                r_rd <= r_wr;
            end else if (w_pop && !w_empty) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PTR_W'(1);
            end
            if (r_rd_valid) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (w_out_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
            if (r_rd_valid && !w_out_pop) begin
                r_oq_cnt <= r_oq_cnt + 2'd1;
            end else if (!r_rd_valid && w_out_pop) begin
                r_oq_cnt <= r_oq_cnt - 2'd1;
            end
        end
    end

endmodule

// File: sv/key_debounce_event_fifo_core.sv
// Top level of the key debounce event queue: config registers and front/back wiring.
//
// Requests enter through push/full. A scan tick samples i_req.keys_down and
// walks the keys one per cycle while the operation queue has room; a key
// raising two events also passes through SCAN_SECOND, and full stays high
// until the walk ends. Pop and clear requests are taken one per cycle while
// full is low; they pass a four-entry operation queue, so ticks, pops and
// clears act in request order. A pop yields one response on o_rsp, shown
// while empty is low and taken with pop; ticks and clears yield none. The
// event ring holds up to QUEUE_DEPTH-1 codes and never checks for space, so
// an overrun wraps the write pointer. When the receiver stalls, two responses
// wait in the output buffer, then four requests in the operation queue, then
// full rises. Configuration writes are taken in any cycle (o_cfg_ready is
// always high) and should be issued while no request is in flight. Reset
// restores the register defaults, resets all key state and empties every queue.
module key_debounce_event_fifo_core #(
    parameter int NUM_KEYS    = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  kdef_pkg::t_in_req                   i_req,
    output logic                                empty,
    input  logic                                pop,
    output kdef_pkg::t_out_rsp                  o_rsp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kdef_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kdef_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    kdef_pkg::t_cfg    r_cfg;
    logic              w_req_ready;
    logic              w_op_valid;
    kdef_pkg::t_op_req w_op;
    logic              w_opq_full;
    logic              w_opq_valid;
    kdef_pkg::t_op_req w_opq_data;
    logic              w_back_ready;
    logic              w_opq_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = !w_req_ready;
    assign w_opq_pop   = w_opq_valid && w_back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_time  <= kdef_pkg::FILTER_TIME_RST;
            r_cfg.long_time    <= kdef_pkg::LONG_TIME_RST;
            r_cfg.repeat_speed <= kdef_pkg::REPEAT_SPEED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kdef_pkg::REG_FILTER_TIME:  r_cfg.filter_time  <= i_cfg_data[kdef_pkg::FT_W-1:0];
                kdef_pkg::REG_LONG_TIME:    r_cfg.long_time    <= i_cfg_data;
                kdef_pkg::REG_REPEAT_SPEED: r_cfg.repeat_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kdef_scan #(
        .NUM_KEYS (NUM_KEYS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (push),
        .i_req       (i_req),
        .o_req_ready (w_req_ready),
        .i_opq_full  (w_opq_full),
        .o_op_valid  (w_op_valid),
        .o_op        (w_op)
    );

    kdef_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_valid),
        .i_data  (w_op),
        .o_full  (w_opq_full),
        .i_pop   (w_opq_pop),
        .o_valid (w_opq_valid),
        .o_data  (w_opq_data)
    );

    kdef_evq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_opq_valid),
        .i_op        (w_opq_data),
        .o_op_ready  (w_back_ready),
        .i_rsp_pop   (pop),
        .o_rsp_empty (empty),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    a_no_opq_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_op_valid && w_opq_full))
        else $error("Operation queue written while full.");

    a_tick_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_req.kind == kdef_pkg::KIND_TICK)) |=> full)
        else $error("Input not held off while a scan tick is walking the keys.");

    a_pop_reaches_opq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_req.kind == kdef_pkg::KIND_POP)) |=> w_opq_valid)
        else $error("Accepted pop request did not reach the operation queue.");
`endif

endmodule

// File: tb/tb_key_debounce_event_fifo_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key debounce event queue core.
module tb_key_debounce_event_fifo_core;

    localparam int NUM_KEYS        = 4;
    localparam int QUEUE_DEPTH     = 16;
    localparam int SETTLE_CYCLES   = 32;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [kdef_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    kdef_pkg::t_in_req               i_req = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    kdef_pkg::t_out_rsp              o_rsp;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [kdef_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [kdef_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    key_debounce_event_fifo_core #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [kdef_pkg::FT_W-1:0]   filter_time;
    logic [kdef_pkg::LT_W-1:0]   long_time;
    logic [kdef_pkg::LT_W-1:0]   repeat_speed;
    logic [kdef_pkg::FC_W-1:0]   debounce_cnt [NUM_KEYS];
    logic                        key_pressed [NUM_KEYS];
    logic [kdef_pkg::LT_W-1:0]   hold_cnt [NUM_KEYS];
    logic [kdef_pkg::LT_W-1:0]   repeat_cnt [NUM_KEYS];
    logic                        long_reported [NUM_KEYS];
    logic [kdef_pkg::CODE_W-1:0] event_ring [QUEUE_DEPTH];
    int                          ring_rd;
    int                          ring_wr;
    kdef_pkg::t_out_rsp          pop_answers [$];

    int error_count = 0;
    int items_sent = 0;
    int stuck_cycles = 0;
    int rx_hold_req = 0;
    int rx_hold = 0;
    int rx_stall = 0;
    bit quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_cycles();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_keys();
        filter_time  = kdef_pkg::FILTER_TIME_RST;
        long_time    = kdef_pkg::LONG_TIME_RST;
        repeat_speed = kdef_pkg::REPEAT_SPEED_RST;
        for (int k = 0; k < NUM_KEYS; k++) begin
            debounce_cnt[k]  = kdef_pkg::FILTER_COUNT_RST;
            key_pressed[k]   = 1'b0;
            hold_cnt[k]      = '0;
            repeat_cnt[k]    = '0;
            long_reported[k] = 1'b0;
        end
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            event_ring[j] = '0;
        end
        ring_rd = 0;
        ring_wr = 0;
    endfunction

    // The ring never checks for space, so an overrun wraps the write pointer.
    function automatic void store_event(input logic [kdef_pkg::CODE_W-1:0] code);
        event_ring[ring_wr] = code;
        ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
    endfunction

    function automatic void debounce_key(input int k, input logic down);
        int ft;
        ft = filter_time;
        if (down) begin
            if (debounce_cnt[k] < ft) begin
                debounce_cnt[k] = kdef_pkg::FC_W'(ft);
            end else if (debounce_cnt[k] < 2 * ft) begin
                debounce_cnt[k] = debounce_cnt[k] + kdef_pkg::FC_W'(1);
            end else begin
                if (!key_pressed[k]) begin
                    key_pressed[k] = 1'b1;
                    store_event(kdef_pkg::CODE_W'(3 * k + kdef_pkg::EV_PRESS));
                end
                if (long_time != 0) begin
                    if (hold_cnt[k] < long_time) begin
                        hold_cnt[k] = hold_cnt[k] + kdef_pkg::LT_W'(1);
                        if (hold_cnt[k] >= long_time) begin
                            store_event(kdef_pkg::CODE_W'(3 * k + kdef_pkg::EV_LONG));
                            long_reported[k] = 1'b1;
                        end
                    end else if (repeat_speed != 0) begin
                        repeat_cnt[k] = repeat_cnt[k] + kdef_pkg::LT_W'(1);
                        if (repeat_cnt[k] >= repeat_speed) begin
                            repeat_cnt[k] = '0;
                            store_event(kdef_pkg::CODE_W'(3 * k + kdef_pkg::EV_PRESS));
                        end
                    end
                end
            end
        end else begin
            if (debounce_cnt[k] > ft) begin
                debounce_cnt[k] = kdef_pkg::FC_W'(ft);
            end else if (debounce_cnt[k] > 0) begin
                debounce_cnt[k] = debounce_cnt[k] - kdef_pkg::FC_W'(1);
            end else if (key_pressed[k]) begin
                key_pressed[k] = 1'b0;
                if (long_reported[k]) begin
                    long_reported[k] = 1'b0;
                end else begin
                    store_event(kdef_pkg::CODE_W'(3 * k + kdef_pkg::EV_RELEASE));
                end
            end
            hold_cnt[k]   = '0;
            repeat_cnt[k] = '0;
        end
    endfunction

    function automatic void predict_events(input kdef_pkg::t_in_req req);
        kdef_pkg::t_out_rsp answer;
        case (req.kind)
            kdef_pkg::KIND_TICK: begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    debounce_key(k, req.keys_down[k]);
                end
            end
            kdef_pkg::KIND_POP: begin
                if (ring_rd == ring_wr) begin
                    answer.event_code  = '0;
                    answer.queue_empty = 1'b1;
                end else begin
                    answer.event_code  = event_ring[ring_rd];
                    answer.queue_empty = 1'b0;
                    ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
                end
                pop_answers.push_back(answer);
            end
            kdef_pkg::KIND_CLEAR: begin
                ring_rd = ring_wr;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [kdef_pkg::KIND_W-1:0] kind,
                             input logic [kdef_pkg::KEYS_W-1:0] keys);
        kdef_pkg::t_in_req req;
        int                gap;
        req.kind      = kind;
        req.keys_down = keys;
        gap = gap_cycles();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push  = 1'b1;
        i_req = req;
        do @(posedge i_clk); while (full);
        predict_events(req);
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic hold_ticks(input logic [kdef_pkg::KEYS_W-1:0] keys, input int count);
        repeat (count) send_item(kdef_pkg::KIND_TICK, keys);
    endtask

    task automatic send_pops(input int count);
        repeat (count) send_item(kdef_pkg::KIND_POP, kdef_pkg::KEYS_W'($urandom_range(0, 15)));
    endtask

    task automatic settle();
        push = 1'b0;
        while (pop_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [kdef_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = kdef_pkg::CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kdef_pkg::REG_FILTER_TIME:  filter_time = kdef_pkg::FT_W'(value);
            kdef_pkg::REG_LONG_TIME:    long_time = kdef_pkg::LT_W'(value);
            kdef_pkg::REG_REPEAT_SPEED: repeat_speed = kdef_pkg::LT_W'(value);
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input int ft, input int lt, input int rs);
        settle();
        write_reg(kdef_pkg::REG_FILTER_TIME, ft);
        write_reg(kdef_pkg::REG_LONG_TIME, lt);
        write_reg(kdef_pkg::REG_REPEAT_SPEED, rs);
    endtask

    task automatic test_empty_queue();
        send_item(kdef_pkg::KIND_POP, 4'h0);
        send_item(kdef_pkg::KIND_CLEAR, 4'hF);
        send_item(KIND_UNUSED, 4'hF);
        send_item(kdef_pkg::KIND_POP, 4'hF);
    endtask

    task automatic test_press_release();
        configure(1, 3, 2);
        hold_ticks(4'b0001, 2);
        hold_ticks(4'b0000, 3);
        send_pops(2);
        hold_ticks(4'hF, 7);
        send_pops(4);
        hold_ticks(4'b1010, 3);
        hold_ticks(4'b0000, 3);
        send_pops(3);
    endtask

    task automatic test_filter_zero();
        configure(0, 0, 0);
        hold_ticks(4'b0101, 1);
        hold_ticks(4'b1010, 1);
        hold_ticks(4'b0101, 1);
        hold_ticks(4'b0000, 2);
        send_pops(5);
    endtask

    task automatic test_overrun();
        configure(1, 1, 1);
        hold_ticks(4'hF, 8);
        send_pops(3);
        send_item(kdef_pkg::KIND_CLEAR, 4'h0);
        send_pops(1);
        hold_ticks(4'hF, 2);
        send_pops(3);
        hold_ticks(4'h0, 3);
        send_pops(2);
    endtask

    // The receiver stops long enough for the operation queue to back up into full.
    task automatic test_backpressure();
        configure(1, 2, 1);
        hold_ticks(4'hF, 4);
        quiet = 1'b1;
        @(posedge i_clk);
        rx_hold_req = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        send_pops(14);
        quiet = 1'b0;
        settle();
    endtask

    task automatic random_traffic(input int count);
        int                          target;
        int                          span;
        int                          r;
        logic [kdef_pkg::KEYS_W-1:0] keys;
        target = items_sent + count;
        while (items_sent < target) begin
            quiet = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                span = 2 * filter_time + long_time + 2 * repeat_speed + 3;
                if (span > 30) begin
                    span = 30;
                end
                keys = kdef_pkg::KEYS_W'($urandom_range(0, 15));
                hold_ticks(keys, $urandom_range(1, span));
                send_pops($urandom_range(0, 4));
            end else if (r < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(kdef_pkg::KIND_TICK, kdef_pkg::KEYS_W'($urandom_range(0, 15)));
                end
            end else if (r < 92) begin
                send_pops($urandom_range(1, 3));
            end else if (r < 97) begin
                send_item(kdef_pkg::KIND_CLEAR, kdef_pkg::KEYS_W'($urandom_range(0, 15)));
            end else begin
                send_item(KIND_UNUSED, kdef_pkg::KEYS_W'($urandom_range(0, 15)));
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_settings();
        configure(2, 4, 3);
        random_traffic(60);
        configure(0, 0, 0);
        random_traffic(40);
        configure(1, 1, 1);
        random_traffic(50);
        configure(127, 1023, 1023);
        random_traffic(30);
        configure($urandom_range(1, 4), $urandom_range(0, 12), $urandom_range(0, 6));
        random_traffic(60);
        configure(3, 6, 2);
        random_traffic(60);
    endtask

    always begin
        @(negedge i_clk);
        if (rx_hold_req > 0) begin
            rx_hold = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold > 0) begin
            pop = 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            pop = 1'b0;
            rx_stall--;
        end else begin
            pop = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        kdef_pkg::t_out_rsp want;
        if (i_rst_n && pop && !empty) begin
            if (pop_answers.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: code %0d empty %0b",
                         $time, o_rsp.event_code, o_rsp.queue_empty);
            end else begin
                want = pop_answers.pop_front();
                if (o_rsp.event_code !== want.event_code) begin
                    error_count++;
                    $display("%0t: event_code expected %0d actual %0d",
                             $time, want.event_code, o_rsp.event_code);
                end
                if (o_rsp.queue_empty !== want.queue_empty) begin
                    error_count++;
                    $display("%0t: queue_empty expected %0b actual %0b",
                             $time, want.queue_empty, o_rsp.queue_empty);
                end
            end
            rx_stall = gap_cycles();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        reset_keys();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_queue();
        test_press_release();
        test_filter_zero();
        test_overrun();
        test_backpressure();
        test_random_settings();
        settle();
        if (pop_answers.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pop_answers.size());
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
